### rtl/core/unique_key_ordered_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unique-key ordered table
// Checks are compiled for simulation and drop out under synthesis.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_KEY_ORDERED_TABLE_ASSERT_SVH
`define UNIQUE_KEY_ORDERED_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property at each rising edge, disabled while reset is asserted
`define UKOT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property at each rising edge, reset cycles included
`define UKOT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define UKOT_ASSERT(lbl, clk, rst_n, prop, msg)
`define UKOT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/ukot_pkg.sv
// ----------------------------------------------------------------------------
// ukot_pkg
// Types and codes shared by the unique-key ordered table.
// ----------------------------------------------------------------------------
package ukot_pkg;

    localparam int KEY_W = 32;
    localparam int PAY_W = 64;

    // Operation codes; the fourth code is ignored
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LIST   = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOTFOUND  = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_LISTED    = 3'd5,
        ST_FULL      = 3'd6
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // Command item
    typedef struct packed {
        t_op                       op;
        logic signed [KEY_W-1:0]   key;
        logic        [PAY_W-1:0]   payload;
    } t_in;

    // Result item
    typedef struct packed {
        t_status                   status;
        logic signed [KEY_W-1:0]   entry_key;
        logic        [PAY_W-1:0]   entry_payload;
        logic                      last;
    } t_res;

    // One stored table entry
    typedef struct packed {
        logic signed [KEY_W-1:0]   key;
        logic        [PAY_W-1:0]   payload;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

### rtl/core/unique_key_ordered_table.sv
// ----------------------------------------------------------------------------
// unique_key_ordered_table
// Bounded table of key/payload entries in insertion order, with unique keys,
// insert, remove with compaction, and ordered listing.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Handshake
//  command   start, busy, i_item           taken when start high and busy low
//  result    o_strobe, o_result            one cycle per item, no back-pressure
//
//  An insert or remove scans the stored entries from accept to result
//  (not on an empty table; a duplicate insert ends at the matching entry);
//  a list gives one result per cycle, after the RAM read and result registers.
//  The scan issues one read of the entry RAM per cycle over the stored
//  entries. Busy falls in the cycle the final result appears.
//  Reset (synchronous, active low) empties the table; RAM contents are not
//  cleared, entries past the count are never read.
// ----------------------------------------------------------------------------
`include "unique_key_ordered_table_assert.svh"

module unique_key_ordered_table #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  ukot_pkg::t_in   i_item,
    output logic            o_strobe,
    output ukot_pkg::t_res  o_result
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    ukot_pkg::t_state                 r_state, n_state;
    logic [CW-1:0]                    r_count, n_count;
    ukot_pkg::t_op                    r_op, n_op;
    logic signed [ukot_pkg::KEY_W-1:0] r_key, n_key;
    logic [ukot_pkg::PAY_W-1:0]       r_pay, n_pay;
    logic [CW-1:0]                    r_rd_idx, n_rd_idx;
    logic                             r_dvld, n_dvld;
    logic [IW-1:0]                    r_didx, n_didx;
    logic                             r_found, n_found;
    logic                             r_strobe, n_strobe;
    ukot_pkg::t_res                   r_res, n_res;

    logic                             ram_we;
    logic [IW-1:0]                    ram_waddr;
    ukot_pkg::t_entry                 ram_wentry;
    logic                             ram_re;
    logic [IW-1:0]                    ram_raddr;
    logic [ukot_pkg::ENTRY_W-1:0]     ram_rdata;
    ukot_pkg::t_entry                 rd_entry;
    logic                             last_d;
    logic                             match;

    // Entry storage
    ukot_ram #(
        .WIDTH (ukot_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = ukot_pkg::t_entry'(ram_rdata);
    assign last_d   = (CW'(r_didx) == (r_count - CW'(1)));
    assign match    = (rd_entry.key == r_key);

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ukot_pkg::S_IDLE;
            r_count  <= '0;
            r_dvld   <= 1'b0;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dvld   <= n_dvld;
            r_found  <= n_found;
            r_strobe <= n_strobe;
            r_rd_idx <= n_rd_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_pay  <= n_pay;
        r_didx <= n_didx;
        r_res  <= n_res;
    end

    // Sequencer: stream reads over the entries and act on each returned entry
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_op       = r_op;
        n_key      = r_key;
        n_pay      = r_pay;
        n_rd_idx   = r_rd_idx;
        n_dvld     = r_dvld;
        n_didx     = r_didx;
        n_found    = r_found;
        n_strobe   = 1'b0;
        n_res      = '0;
        n_res.last = 1'b1;
        ram_we     = 1'b0;
        ram_waddr  = r_didx;
        ram_wentry = rd_entry;
        ram_re     = 1'b0;
        ram_raddr  = r_rd_idx[IW-1:0];

        unique case (r_state)
            ukot_pkg::S_IDLE: begin
                if (start) begin
                    n_op  = i_item.op;
                    n_key = i_item.key;
                    n_pay = i_item.payload;
                    if (r_count == '0) begin
                        // Empty table: answer at once
                        unique case (i_item.op)
                            ukot_pkg::OP_INSERT: begin
                                ram_we             = 1'b1;
                                ram_waddr          = '0;
                                ram_wentry.key     = i_item.key;
                                ram_wentry.payload = i_item.payload;
                                n_count            = CW'(1);
                                n_strobe           = 1'b1;
                                n_res.status       = ukot_pkg::ST_INSERTED;
                            end
                            ukot_pkg::OP_REMOVE: begin
                                n_strobe     = 1'b1;
                                n_res.status = ukot_pkg::ST_NOTFOUND;
                            end
                            ukot_pkg::OP_LIST: begin
                                n_strobe     = 1'b1;
                                n_res.status = ukot_pkg::ST_EMPTY;
                            end
                            default: begin
                            end
                        endcase
                    end else if (i_item.op == ukot_pkg::OP_INSERT
                              || i_item.op == ukot_pkg::OP_REMOVE
                              || i_item.op == ukot_pkg::OP_LIST) begin
                        // Launch the scan at entry zero
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_rd_idx  = CW'(1);
                        n_dvld    = 1'b1;
                        n_didx    = '0;
                        n_found   = 1'b0;
                        n_state   = ukot_pkg::S_SCAN;
                    end
                end
            end

            ukot_pkg::S_SCAN: begin
                // Issue the next read while entries remain
                if (r_rd_idx < r_count) begin
                    ram_re   = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_dvld   = 1'b1;
                    n_didx   = r_rd_idx[IW-1:0];
                end else begin
                    n_dvld = 1'b0;
                end

                if (r_dvld) begin
                    unique case (r_op)
                        ukot_pkg::OP_INSERT: begin
                            if (match) begin
                                n_strobe     = 1'b1;
                                n_res.status = ukot_pkg::ST_DUPLICATE;
                                n_dvld       = 1'b0;
                                n_state      = ukot_pkg::S_IDLE;
                            end else if (last_d) begin
                                n_strobe = 1'b1;
                                n_state  = ukot_pkg::S_IDLE;
                                if (r_count == CW'(MAX_ENTRIES)) begin
                                    n_res.status = ukot_pkg::ST_FULL;
                                end else begin
                                    // Append at the tail
                                    ram_we             = 1'b1;
                                    ram_waddr          = r_count[IW-1:0];
                                    ram_wentry.key     = r_key;
                                    ram_wentry.payload = r_pay;
                                    n_count            = r_count + CW'(1);
                                    n_res.status       = ukot_pkg::ST_INSERTED;
                                end
                            end
                        end
                        ukot_pkg::OP_REMOVE: begin
                            // Past the removed entry, move each entry down one place
                            if (r_found) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_didx - IW'(1);
                            end else if (match) begin
                                n_found = 1'b1;
                            end
                            if (last_d) begin
                                n_strobe = 1'b1;
                                n_state  = ukot_pkg::S_IDLE;
                                if (r_found || match) begin
                                    n_count      = r_count - CW'(1);
                                    n_res.status = ukot_pkg::ST_REMOVED;
                                end else begin
                                    n_res.status = ukot_pkg::ST_NOTFOUND;
                                end
                            end
                        end
                        ukot_pkg::OP_LIST: begin
                            n_strobe            = 1'b1;
                            n_res.status        = ukot_pkg::ST_LISTED;
                            n_res.entry_key     = rd_entry.key;
                            n_res.entry_payload = rd_entry.payload;
                            n_res.last          = last_d;
                            if (last_d) begin
                                n_state = ukot_pkg::S_IDLE;
                            end
                        end
                        default: begin
                            n_dvld  = 1'b0;
                            n_state = ukot_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            default: begin
                n_state = ukot_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ukot_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // Count stays within the table
    `UKOT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_ENTRIES),
                 "entry count overflow")
    // Writes land inside the live region or at the tail
    `UKOT_ASSERT(a_wr_in_range, i_clk, i_rst_n, ram_we |-> (CW'(ram_waddr) <= r_count),
                 "RAM write past tail")
    // The final result of an item frees the block
    `UKOT_ASSERT(a_last_idle, i_clk, i_rst_n, (o_strobe && o_result.last) |-> !busy,
                 "busy after final result")
    // A non-final result only comes from an ongoing list
    `UKOT_ASSERT(a_mid_busy, i_clk, i_rst_n,
                 (o_strobe && !o_result.last)
                     |-> (busy && o_result.status == ukot_pkg::ST_LISTED),
                 "stray non-final result")
    // Count moves only while an item is handled
    `UKOT_ASSERT(a_count_step, i_clk, i_rst_n,
                 (r_count != $past(r_count)) |-> $past(start || busy),
                 "count changed while idle")

endmodule

### rtl/core/ukot_ram.sv
// ----------------------------------------------------------------------------
// ukot_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ukot_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/ukot_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukot_reply_checker
// Watches the command and result channels of the unique-key ordered table,
// keeps a shadow copy of the stored entries, works out the replies that each
// accepted command owes and compares every strobed result, field by field,
// with the oldest reply still owed.
// ----------------------------------------------------------------------------
module ukot_reply_checker
    import ukot_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_busy,
    input  t_in   i_cmd,
    input  logic  i_strobe,
    input  t_res  i_result,
    output int    o_fail_count,
    output int    o_owed_count
);

    // Shadow table, oldest entry at index zero
    t_entry entry_mem [MAX_ENTRIES];
    int     stored_cnt;
    t_res   owed_replies [$];

    initial begin
        o_fail_count = 0;
        o_owed_count = 0;
        stored_cnt   = 0;
    end

    function automatic t_res make_reply(input t_status status,
                                        input logic signed [KEY_W-1:0] key,
                                        input logic [PAY_W-1:0] payload,
                                        input logic is_last);
        t_res reply;
        reply.status        = status;
        reply.entry_key     = key;
        reply.entry_payload = payload;
        reply.last          = is_last;
        return reply;
    endfunction

    // Position of the key among stored entries, or stored_cnt when absent
    function automatic int locate_key(input logic signed [KEY_W-1:0] key);
        int idx;
        int pos;
        pos = stored_cnt;
        for (idx = stored_cnt - 1; idx >= 0; idx--) begin
            if (entry_mem[idx].key == key) begin
                pos = idx;
            end
        end
        return pos;
    endfunction

    // Update the shadow table and queue the replies that one command owes
    task automatic apply_table_op(input t_in cmd);
        int pos;
        int idx;
        pos = locate_key(cmd.key);
        case (cmd.op)
            OP_INSERT: begin
                // duplicate check wins over the full check
                if (pos < stored_cnt) begin
                    owed_replies.push_back(make_reply(ST_DUPLICATE, '0, '0, 1'b1));
                end else if (stored_cnt >= MAX_ENTRIES) begin
                    owed_replies.push_back(make_reply(ST_FULL, '0, '0, 1'b1));
                end else begin
                    entry_mem[stored_cnt].key     = cmd.key;
                    entry_mem[stored_cnt].payload = cmd.payload;
                    stored_cnt++;
                    owed_replies.push_back(make_reply(ST_INSERTED, '0, '0, 1'b1));
                end
            end
            OP_REMOVE: begin
                if (pos >= stored_cnt) begin
                    owed_replies.push_back(make_reply(ST_NOTFOUND, '0, '0, 1'b1));
                end else begin
                    // close the gap, keep the order of the rest
                    for (idx = pos; idx + 1 < stored_cnt; idx++) begin
                        entry_mem[idx] = entry_mem[idx + 1];
                    end
                    stored_cnt--;
                    owed_replies.push_back(make_reply(ST_REMOVED, '0, '0, 1'b1));
                end
            end
            OP_LIST: begin
                if (stored_cnt == 0) begin
                    owed_replies.push_back(make_reply(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    for (idx = 0; idx < stored_cnt; idx++) begin
                        owed_replies.push_back(make_reply(ST_LISTED, entry_mem[idx].key,
                                                          entry_mem[idx].payload,
                                                          idx + 1 == stored_cnt));
                    end
                end
            end
            default: begin
                // unused op code: no reply, table unchanged
            end
        endcase
    endtask

    // Check results first, then take the command of this edge
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            stored_cnt = 0;
            owed_replies.delete();
        end else begin
            if (i_strobe) begin
                if (owed_replies.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: result with none owed: status %0d key %h payload %h last %b",
                             $time, i_result.status, i_result.entry_key,
                             i_result.entry_payload, i_result.last);
                end else begin
                    want = owed_replies.pop_front();
                    if (i_result.status !== want.status
                            || i_result.entry_key !== want.entry_key
                            || i_result.entry_payload !== want.entry_payload
                            || i_result.last !== want.last) begin
                        o_fail_count = o_fail_count + 1;
                        $display("%0t: mismatch expected status %0d key %h payload %h last %b",
                                 $time, want.status, want.entry_key,
                                 want.entry_payload, want.last);
                        $display("%0t:          actual   status %0d key %h payload %h last %b",
                                 $time, i_result.status, i_result.entry_key,
                                 i_result.entry_payload, i_result.last);
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_table_op(i_cmd);
            end
        end
        o_owed_count = owed_replies.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, remove and list commands into the unique-key ordered table:
// a directed walk through empty, duplicate, absent-key and full cases, then
// random commands over a small key pool so that the table fills and drains.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import ukot_pkg::*;

    localparam int         MAX_ENTRIES  = 16;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_ITEMS = 130;
    localparam int         POOL_SIZE    = 24;
    localparam int         DRAIN_CYCLES = 3 * MAX_ENTRIES;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  cmd     = '0;
    logic busy;
    logic o_strobe;
    t_res o_result;

    int          fail_count;
    int          owed_count;
    int          cycle_cnt     = 0;
    bit          steady_sender = 1'b0;
    logic [31:0] key_pool [POOL_SIZE];

    unique_key_ordered_table #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    ukot_reply_checker #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_owed_count (owed_count)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one item at a falling edge and hold it until it is taken
    task automatic send_item(input logic [1:0] op, input logic [31:0] key,
                             input logic [63:0] payload);
        if (!steady_sender && $urandom_range(99) < 7) begin
            start = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        start       = 1'b1;
        cmd.op      = t_op'(op);
        cmd.key     = key;
        cmd.payload = payload;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off until every owed result is back
    task automatic wait_drained();
        start = 1'b0;
        while (owed_count != 0 || busy) @(negedge i_clk);
    endtask

    initial begin
        int          sent;
        int          pick;
        int          idx;
        bit          filling;
        logic [1:0]  op;
        logic [31:0] key;

        for (idx = 0; idx < POOL_SIZE; idx++) begin
            key_pool[idx] = $urandom;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Empty table: list and remove
        send_item(OP_LIST, 32'h0, 64'h0);
        send_item(OP_REMOVE, 32'h8000_0000, 64'h0);
        // Key and payload extremes, duplicate, absent key, unused op code
        send_item(OP_INSERT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 64'h0);
        send_item(OP_INSERT, 32'h8000_0000, 64'h1234_5678_9ABC_DEF0);
        send_item(OP_REMOVE, 32'h0000_3039, 64'h0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_LIST, 32'h0, 64'h0);
        // Remove the head so the tail moves down
        send_item(OP_REMOVE, 32'h8000_0000, 64'h0);
        // Fill to capacity, then hit the full and duplicate-when-full cases
        for (idx = 1; idx < MAX_ENTRIES; idx++) begin
            send_item(OP_INSERT, 32'h0001_0000 + 32'(idx), {$urandom, $urandom});
        end
        send_item(OP_INSERT, 32'hFFFF_FFFF, 64'hA5A5_A5A5_5A5A_5A5A);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 64'h0);
        send_item(OP_LIST, 32'h0, 64'h0);
        send_item(OP_REMOVE, 32'h0001_0000 + 32'(MAX_ENTRIES - 1), 64'h0);
        wait_drained();

        // Random commands: alternate fill-heavy and drain-heavy phases
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            steady_sender = (sent >= 60 && sent < 100);
            filling       = ((sent / 30) % 2) == 0;
            pick          = $urandom_range(99);
            if (pick < (filling ? 65 : 25)) begin
                op = OP_INSERT;
            end else if (pick < (filling ? 80 : 75)) begin
                op = OP_REMOVE;
            end else if (pick < 97) begin
                op = OP_LIST;
            end else begin
                op = OP_UNUSED;
            end
            key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                            : $urandom;
            send_item(op, key, {$urandom, $urandom});
            if (op != OP_UNUSED) begin
                sent++;
                if (sent == 120) begin
                    wait_drained();
                end
            end
        end

        // Drain and give the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
